[design/ppmd_pkg.sv]
// Shared constants and types of the point to polyline distance block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ppmd_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned AddrW       = $clog2(MaxVertices);
  localparam int unsigned CountW      = AddrW + 1;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned DistW       = 33;
  localparam int unsigned MslW        = 16;
  localparam int unsigned ThrW        = 2 * MslW;
  localparam int unsigned QDepth      = 2;
  localparam int unsigned QPtrW       = $clog2(QDepth);
  localparam int unsigned QCntW       = $clog2(QDepth + 1);

  localparam logic [MslW-1:0] MslReset = 16'd10;
  localparam logic [ThrW-1:0] ThrReset = 32'd100;

  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_RESTART,
    KIND_QUERY
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } cmd_t;

endpackage
`default_nettype wire

[design/ppmd_if.sv]
// Valid/ready channels of the block: input item beats and result beats.
// Depends on ppmd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ppmd_item_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      command;
  logic                                      start_new;
  logic signed [ppmd_pkg::CoordW-1:0]        coord_x;
  logic signed [ppmd_pkg::CoordW-1:0]        coord_y;

  modport source (output valid, command, start_new, coord_x, coord_y, input ready);
  modport sink   (input valid, command, start_new, coord_x, coord_y, output ready);
endinterface

interface ppmd_res_if;
  logic                           valid;
  logic                           ready;
  logic [ppmd_pkg::DistW-1:0]     distance;
  logic                           valid_res;

  modport source (output valid, distance, valid_res, input ready);
  modport sink   (input valid, distance, valid_res, output ready);
endinterface
`default_nettype wire

[design/ppmd_front.sv]
// Front end: accepts item beats, classifies them and holds them in a short queue.
// Depends on ppmd_pkg and ppmd_if.
`timescale 1ns / 1ps
`default_nettype none
module ppmd_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  ppmd_item_if.sink            item_i,
  output logic                 cmd_valid_o,
  output ppmd_pkg::cmd_t       cmd_o,
  input  wire                  cmd_pop_i
);

  localparam int unsigned QCntW = ppmd_pkg::QCntW;

  ppmd_pkg::cmd_t                   ent_q [ppmd_pkg::QDepth];
  logic [ppmd_pkg::QPtrW-1:0]       wp_q, wp_d, rp_q, rp_d;
  logic [ppmd_pkg::QCntW-1:0]       cnt_q, cnt_d;
  ppmd_pkg::cmd_t                   cls;
  logic                             push, pop;

  always_comb begin
    cls.x = item_i.coord_x;
    cls.y = item_i.coord_y;
    if (item_i.command) begin
      cls.kind = ppmd_pkg::KIND_QUERY;
    end else if (item_i.start_new) begin
      cls.kind = ppmd_pkg::KIND_RESTART;
    end else begin
      cls.kind = ppmd_pkg::KIND_APPEND;
    end
  end

  assign item_i.ready = (cnt_q != QCntW'(ppmd_pkg::QDepth));
  assign push         = item_i.valid && item_i.ready;
  assign cmd_valid_o  = (cnt_q != '0);
  assign cmd_o        = ent_q[rp_q];
  assign pop          = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = (wp_q == ppmd_pkg::QPtrW'(ppmd_pkg::QDepth - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop) begin
      rp_d = (rp_q == ppmd_pkg::QPtrW'(ppmd_pkg::QDepth - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(ppmd_pkg::QDepth))
    else $error("queue fill above depth");

endmodule
`default_nettype wire

[design/ppmd_seg.sv]
// Segment unit: distance floor, point to segment; nearer endpoint if l2 <= thr_i.
// One shared 33x33 multiplier, bit-serial divider and square root; uses ppmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppmd_seg (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire signed [ppmd_pkg::CoordW-1:0]    ax_i,
  input  wire signed [ppmd_pkg::CoordW-1:0]    ay_i,
  input  wire signed [ppmd_pkg::CoordW-1:0]    bx_i,
  input  wire signed [ppmd_pkg::CoordW-1:0]    by_i,
  input  wire signed [ppmd_pkg::CoordW-1:0]    px_i,
  input  wire signed [ppmd_pkg::CoordW-1:0]    py_i,
  input  wire        [ppmd_pkg::ThrW-1:0]      thr_i,
  output logic                                 done_o,
  output logic       [ppmd_pkg::DistW-1:0]     dist_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;

  localparam logic [3:0] OP_ABX2  = 4'd0;
  localparam logic [3:0] OP_ABY2  = 4'd1;
  localparam logic [3:0] OP_DOTX  = 4'd2;
  localparam logic [3:0] OP_DOTY  = 4'd3;
  localparam logic [3:0] OP_CRP   = 4'd4;
  localparam logic [3:0] OP_CRN   = 4'd5;
  localparam logic [3:0] OP_APX2  = 4'd6;
  localparam logic [3:0] OP_APY2  = 4'd7;
  localparam logic [3:0] OP_BPX2  = 4'd8;
  localparam logic [3:0] OP_BPY2  = 4'd9;
  localparam logic [3:0] OP_HH    = 4'd10;
  localparam logic [3:0] OP_HL    = 4'd11;
  localparam logic [3:0] OP_LL    = 4'd12;
  localparam logic [3:0] OP_END   = 4'd13;

  localparam logic [7:0] DivSteps  = 8'd131;
  localparam logic [7:0] RootSteps = 8'd32;

  logic [2:0]          state_q, state_d;
  logic [3:0]          op_q, op_d, pop_q;
  logic                pvalid_q, pvalid_d, done_q, done_d;
  logic signed [32:0]  abx_q, aby_q, apx_q, apy_q, bpx_q, bpy_q;
  logic signed [32:0]  abx_d, aby_d, apx_d, apy_d, bpx_d, bpy_d;
  logic signed [67:0]  l2_q, dot_q, cr_q, da_q, db_q;
  logic signed [67:0]  l2_d, dot_d, cr_d, da_d, db_d;
  logic [65:0]         prod_q, prod_d, crmag_q, crmag_d, quo_q, quo_d, v_q, v_d;
  logic                psign_q, psign_d;
  logic [131:0]        num_q, num_d;
  logic [65:0]         rem_q, rem_d;
  logic [34:0]         rr_q, rr_d;
  logic [32:0]         r_q, r_d;
  logic [7:0]          cnt_q, cnt_d;
  logic [32:0]         ma, mb;
  logic                sa, sb, issue;
  logic signed [67:0]  addend;
  logic [66:0]         div_sh;
  logic [36:0]         rt_sh, rt_trial;
  logic                long_seg;
  logic signed [67:0]  cr_abs;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  always_comb begin
    sa = 1'b0;
    sb = 1'b0;
    ma = '0;
    mb = '0;
    unique case (op_q)
      OP_ABX2: begin ma = mag33(abx_q); mb = mag33(abx_q); end
      OP_ABY2: begin ma = mag33(aby_q); mb = mag33(aby_q); end
      OP_DOTX: begin ma = mag33(abx_q); mb = mag33(apx_q); sa = abx_q[32]; sb = apx_q[32]; end
      OP_DOTY: begin ma = mag33(aby_q); mb = mag33(apy_q); sa = aby_q[32]; sb = apy_q[32]; end
      OP_CRP:  begin ma = mag33(abx_q); mb = mag33(apy_q); sa = abx_q[32]; sb = apy_q[32]; end
      OP_CRN:  begin ma = mag33(aby_q); mb = mag33(apx_q); sa = aby_q[32]; sb = apx_q[32]; end
      OP_APX2: begin ma = mag33(apx_q); mb = mag33(apx_q); end
      OP_APY2: begin ma = mag33(apy_q); mb = mag33(apy_q); end
      OP_BPX2: begin ma = mag33(bpx_q); mb = mag33(bpx_q); end
      OP_BPY2: begin ma = mag33(bpy_q); mb = mag33(bpy_q); end
      OP_HH:   begin ma = crmag_q[65:33]; mb = crmag_q[65:33]; end
      OP_HL:   begin ma = crmag_q[65:33]; mb = crmag_q[32:0]; end
      OP_LL:   begin ma = crmag_q[32:0];  mb = crmag_q[32:0]; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod_d   = 66'(ma) * 66'(mb);
  assign psign_d  = sa ^ sb;
  assign addend   = psign_q ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});
  assign div_sh   = {rem_q, num_q[131]};
  assign rt_sh    = {rr_q, v_q[65:64]};
  assign rt_trial = {2'b00, r_q, 2'b01};
  assign long_seg = (l2_q[65:0] > {34'b0, thr_i});
  assign cr_abs   = cr_q[67] ? -cr_q : cr_q;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    pvalid_d = 1'b0;
    done_d   = 1'b0;
    abx_d = abx_q; aby_d = aby_q; apx_d = apx_q;
    apy_d = apy_q; bpx_d = bpx_q; bpy_d = bpy_q;
    l2_d = l2_q; dot_d = dot_q; cr_d = cr_q; da_d = da_q; db_d = db_q;
    crmag_d = crmag_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    v_d     = v_q;
    rr_d    = rr_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    issue   = ((state_q == S_MUL) && (op_q < OP_HH)) || ((state_q == S_SQ) && (op_q < OP_END));

    if (issue) begin
      op_d     = op_q + 4'd1;
      pvalid_d = 1'b1;
    end
    if (pvalid_q) begin
      case (pop_q)
        OP_ABX2, OP_ABY2: l2_d  = l2_q + addend;
        OP_DOTX, OP_DOTY: dot_d = dot_q + addend;
        OP_CRP:           cr_d  = cr_q + addend;
        OP_CRN:           cr_d  = cr_q - addend;
        OP_APX2, OP_APY2: da_d  = da_q + addend;
        OP_BPX2, OP_BPY2: db_d  = db_q + addend;
        OP_HH:            num_d = num_q + ({66'b0, prod_q} << 66);
        OP_HL:            num_d = num_q + ({66'b0, prod_q} << 34);
        default:          num_d = num_q + {66'b0, prod_q};
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          abx_d = $signed({bx_i[31], bx_i}) - $signed({ax_i[31], ax_i});
          aby_d = $signed({by_i[31], by_i}) - $signed({ay_i[31], ay_i});
          apx_d = $signed({px_i[31], px_i}) - $signed({ax_i[31], ax_i});
          apy_d = $signed({py_i[31], py_i}) - $signed({ay_i[31], ay_i});
          bpx_d = $signed({px_i[31], px_i}) - $signed({bx_i[31], bx_i});
          bpy_d = $signed({py_i[31], py_i}) - $signed({by_i[31], by_i});
          l2_d = '0; dot_d = '0; cr_d = '0; da_d = '0; db_d = '0;
          op_d    = OP_ABX2;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (op_q == OP_HH) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        rr_d  = '0;
        r_d   = '0;
        cnt_d = RootSteps;
        if (!long_seg) begin
          v_d     = (da_q[65:0] < db_q[65:0]) ? da_q[65:0] : db_q[65:0];
          state_d = S_ROOT;
        end else if (dot_q > $signed({2'b00, l2_q[65:0]})) begin
          v_d     = db_q[65:0];
          state_d = S_ROOT;
        end else if (dot_q[67]) begin
          v_d     = da_q[65:0];
          state_d = S_ROOT;
        end else begin
          crmag_d = cr_abs[65:0];
          num_d   = '0;
          op_d    = OP_HH;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (op_q == OP_END) begin
          rem_d   = '0;
          cnt_d   = DivSteps;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sh >= {1'b0, l2_q[65:0]}) begin
          rem_d = 66'(div_sh - {1'b0, l2_q[65:0]});
          quo_d = {quo_q[64:0], 1'b1};
        end else begin
          rem_d = div_sh[65:0];
          quo_d = {quo_q[64:0], 1'b0};
        end
        num_d = {num_q[130:0], 1'b0};
        cnt_d = cnt_q - 8'd1;
        if (cnt_q == '0) begin
          v_d     = quo_d;
          rr_d    = '0;
          r_d     = '0;
          cnt_d   = RootSteps;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (rt_sh >= rt_trial) begin
          rr_d = 35'(rt_sh - rt_trial);
          r_d  = {r_q[31:0], 1'b1};
        end else begin
          rr_d = rt_sh[34:0];
          r_d  = {r_q[31:0], 1'b0};
        end
        v_d   = {v_q[63:0], 2'b00};
        cnt_d = cnt_q - 8'd1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_ABX2;
      pvalid_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      pvalid_q <= pvalid_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    psign_q <= psign_d;
    pop_q   <= op_q;
    abx_q <= abx_d; aby_q <= aby_d; apx_q <= apx_d;
    apy_q <= apy_d; bpx_q <= bpx_d; bpy_q <= bpy_d;
    l2_q <= l2_d; dot_q <= dot_d; cr_q <= cr_d; da_q <= da_d; db_q <= db_d;
    crmag_q <= crmag_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    v_q     <= v_d;
    rr_q    <= rr_d;
    r_q     <= r_d;
  end

  assign done_o = done_q;
  assign dist_o = r_q;

endmodule
`default_nettype wire

[design/ppmd_back.sv]
// Back end: vertex store, command execution and per-query segment walk.
// Depends on ppmd_pkg, ppmd_if and ppmd_seg.
`timescale 1ns / 1ps
`default_nettype none
module ppmd_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cmd_valid_i,
  input  wire ppmd_pkg::cmd_t          cmd_i,
  output logic                         cmd_pop_o,
  input  wire                          cfg_we_i,
  input  wire [ppmd_pkg::MslW-1:0]     cfg_wdata_i,
  ppmd_res_if.source                   res_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_LA   = 3'd1;
  localparam logic [2:0] B_LB   = 3'd2;
  localparam logic [2:0] B_SEG  = 3'd3;
  localparam logic [2:0] B_FIN  = 3'd4;

  localparam int unsigned AddrW  = ppmd_pkg::AddrW;
  localparam int unsigned CountW = ppmd_pkg::CountW;
  localparam int unsigned CoordW = ppmd_pkg::CoordW;
  localparam int unsigned DistW  = ppmd_pkg::DistW;

  logic [CoordW-1:0]          mem_x_q [ppmd_pkg::MaxVertices];
  logic [CoordW-1:0]          mem_y_q [ppmd_pkg::MaxVertices];
  logic [CoordW-1:0]          rdx_q, rdy_q;
  logic [2:0]                 state_q, state_d;
  logic [CountW-1:0]          count_q, count_d;
  logic [AddrW-1:0]           idx_q, idx_d, rd_addr, wr_addr;
  logic                       wr_en, go_q, go_d;
  logic [ppmd_pkg::ThrW-1:0]  thr_q;
  logic signed [CoordW-1:0]   ax_q, ay_q, bx_q, by_q, px_q, py_q;
  logic signed [CoordW-1:0]   ax_d, ay_d, bx_d, by_d, px_d, py_d;
  logic [DistW-1:0]           best_q, best_d, seg_dist;
  logic                       seg_done, slot_free;
  logic                       res_valid_q, res_valid_d, res_ok_q, res_ok_d;
  logic [DistW-1:0]           res_dist_q, res_dist_d;
  logic [CountW-1:0]          next_idx;

  assign slot_free = !res_valid_q || res_o.ready;
  assign next_idx  = {1'b0, idx_q} + 1'b1;
  assign wr_addr   = (cmd_i.kind == ppmd_pkg::KIND_RESTART) ? '0 : count_q[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    go_d        = 1'b0;
    cmd_pop_o   = 1'b0;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q; px_d = px_q; py_d = py_q;
    best_d      = best_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_dist_d  = res_dist_q;
    res_ok_d    = res_ok_q;

    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            ppmd_pkg::KIND_QUERY: begin
              if (count_q < CountW'(2)) begin
                if (slot_free) begin
                  cmd_pop_o   = 1'b1;
                  res_valid_d = 1'b1;
                  res_dist_d  = '0;
                  res_ok_d    = 1'b0;
                end
              end else begin
                cmd_pop_o = 1'b1;
                px_d      = cmd_i.x;
                py_d      = cmd_i.y;
                best_d    = '1;
                state_d   = B_LA;
              end
            end
            ppmd_pkg::KIND_RESTART: begin
              cmd_pop_o = 1'b1;
              wr_en     = 1'b1;
              count_d   = CountW'(1);
            end
            default: begin
              cmd_pop_o = 1'b1;
              if (count_q < CountW'(ppmd_pkg::MaxVertices)) begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
          endcase
        end
      end
      B_LA: begin
        ax_d    = rdx_q;
        ay_d    = rdy_q;
        rd_addr = AddrW'(1);
        idx_d   = AddrW'(1);
        state_d = B_LB;
      end
      B_LB: begin
        bx_d    = rdx_q;
        by_d    = rdy_q;
        go_d    = 1'b1;
        state_d = B_SEG;
      end
      B_SEG: begin
        if (seg_done) begin
          if (seg_dist < best_q) begin
            best_d = seg_dist;
          end
          if (next_idx < count_q) begin
            ax_d    = bx_q;
            ay_d    = by_q;
            rd_addr = next_idx[AddrW-1:0];
            idx_d   = next_idx[AddrW-1:0];
            state_d = B_LB;
          end else begin
            state_d = B_FIN;
          end
        end
      end
      B_FIN: begin
        if (slot_free) begin
          res_valid_d = 1'b1;
          res_dist_d  = best_q;
          res_ok_d    = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      go_q        <= 1'b0;
      res_valid_q <= 1'b0;
      thr_q       <= ppmd_pkg::ThrReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      go_q        <= go_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        thr_q <= 32'(cfg_wdata_i) * 32'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d; px_q <= px_d; py_q <= py_d;
    best_q     <= best_d;
    res_dist_q <= res_dist_d;
    res_ok_q   <= res_ok_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x_q[wr_addr] <= cmd_i.x;
      mem_y_q[wr_addr] <= cmd_i.y;
    end
    rdx_q <= mem_x_q[rd_addr];
    rdy_q <= mem_y_q[rd_addr];
  end

  ppmd_seg u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .ax_i    (ax_q),
    .ay_i    (ay_q),
    .bx_i    (bx_q),
    .by_i    (by_q),
    .px_i    (px_q),
    .py_i    (py_q),
    .thr_i   (thr_q),
    .done_o  (seg_done),
    .dist_o  (seg_dist)
  );

  assign res_o.valid     = res_valid_q;
  assign res_o.distance  = res_dist_q;
  assign res_o.valid_res = res_ok_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(ppmd_pkg::MaxVertices))
    else $error("vertex count above store depth");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SEG) |-> ({1'b0, idx_q} < count_q))
    else $error("segment walk past last vertex");

  a_done_in_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_done |-> (state_q == B_SEG))
    else $error("segment unit finished outside a walk");

  a_go_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_q |-> $past(state_q == B_LB))
    else $error("segment start without vertex load");

endmodule
`default_nettype wire

[design/point_to_polyline_min_distance.sv]
// Least distance from a query point to a stored polyline of up to 1024 vertices.
// A query over n vertices walks its n-1 segments in the segment unit; a segment
// whose nearest point is an endpoint needs only the bit-serial square root (33
// steps), and one whose nearest point is the perpendicular foot also needs the
// bit-serial divider (132 steps). A two-beat queue lets new items be taken while
// a query runs.
`timescale 1ns / 1ps
`default_nettype none
module point_to_polyline_min_distance (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  ppmd_item_if.sink                    item_i,
  ppmd_res_if.source                   res_o,
  input  wire                          cfg_we_i,
  input  wire [ppmd_pkg::MslW-1:0]     cfg_wdata_i
);

  logic            cmd_valid, cmd_pop;
  ppmd_pkg::cmd_t  cmd;

  ppmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ppmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire
